/* src/bra_pkg.sv */
// bra_pkg: shared types and constants for the bitmap run allocator
// depends on nothing
package bra_pkg;
  localparam int MaxDivisionsDefault = 1024;
  localparam int DivBytesMax = 4096;
  localparam logic [22:0] FreeMax = 23'h7FFFFF;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_DOUBLE  = 3'd2,
    ST_OUTSIDE = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_DIV  = 2'd1;
  localparam logic [1:0] REG_CNT  = 2'd2;

  // divider handshake between sequencer and shared divider
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [12:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [12:0] remainder;
  } div_rsp_t;
endpackage

/* src/bitmap_run_allocator.sv */
// bitmap_run_allocator: top level, sequencer, owner map memory and result register
// depends on bra_pkg and bra_divider
//
// First-fit allocator over one region of equal divisions. One beat goes in, one
// result beat comes out. in_ready is low while a command is in progress, and
// also while a result beat waits for out_ready. An allocate is accepted and
// then runs the rounding division on the shared divider. Unless the size is
// zero or above the free bytes, the scan then visits map entries with a read
// state and a check state per entry (up to divisions_in_use entries). After
// that it stamps each division of the run and posts the result. A free is
// accepted and divides its offset on the same divider, then does the first
// lookup with a read state and a check state. It then clears each division
// of the run with a check state and a read state, makes the final check and
// posts the result. After reset and after every cfg write to BASE, DIV or CNT
// the map is cleared by a sweep over all MAX_DIVISIONS entries, during which
// no beat is taken; cfg writes are taken as always. The map is a memory with
// one write port and one registered read port, one entry per cycle.
module bitmap_run_allocator
  import bra_pkg::*;
#(
  parameter int MAX_DIVISIONS = MaxDivisionsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [23:0] in_request_bytes,
  input  logic [3:0]  in_align_log2,
  input  logic [31:0] in_free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_granted_address,
  output logic [2:0]  out_status,
  output logic [22:0] out_bytes_left
);
  localparam int AW = $clog2(MAX_DIVISIONS);
  localparam int CW = $clog2(MAX_DIVISIONS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIVWAIT, S_SCAN, S_SCANWAIT, S_STAMP,
    S_FRDWAIT, S_FRCHK, S_FRWALK, S_FRNEXT, S_DONE
  } state_t;

  // configuration registers
  logic [31:0] base_r;
  logic [12:0] divb_r;
  logic [10:0] cntcfg_r;
  logic [12:0] ediv;
  logic [CW-1:0] ecnt;

  always_comb begin
    if (divb_r == '0) ediv = 13'd1;
    else if (divb_r > 13'(DivBytesMax)) ediv = 13'(DivBytesMax);
    else ediv = divb_r;
    if (cntcfg_r == '0) ecnt = CW'(1);
    else if ({21'd0, cntcfg_r} > 32'(MAX_DIVISIONS)) ecnt = CW'(MAX_DIVISIONS);
    else ecnt = CW'(cntcfg_r);
  end

  // region byte span, one multiply, registered
  logic [43:0] span_r;
  logic [22:0] init_free;
  assign init_free = (span_r > 44'(FreeMax)) ? FreeMax : span_r[22:0];

  state_t      state_r;
  logic [AW:0] clr_r;
  logic        init_pend_r;
  logic [22:0] free_r;
  logic [7:0]  id_r;

  // command latch
  logic        cmd_r;
  logic [23:0] size_r;
  logic [31:0] mask_r;
  logic [31:0] faddr_r;

  // scan state
  logic [CW-1:0] idx_r;
  logic [CW-1:0] run_len_r;
  logic [AW-1:0] first_free_r;
  logic [31:0]   cand_r;       // base + idx*div, stepped by div
  logic [31:0]   need_r;
  logic [31:0]   run_addr_r;
  logic [7:0]    fid_r;
  logic [CW-1:0] freed_r;
  logic [31:0]   div_q_r;

  // owner map
  logic [7:0]    mem [MAX_DIVISIONS];
  logic [7:0]    rd_r;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  div_req_t dreq;
  div_rsp_t drsp;
  bra_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // result register
  logic [31:0] ogr_r;
  logic [2:0]  ost_r;
  logic        ovalid_r;

  logic accept;
  assign in_ready = (state_r == S_IDLE) && !ovalid_r;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  // combinational control of memory and divider
  always_comb begin
    we    = 1'b0;
    waddr = clr_r[AW-1:0];
    wdata = '0;
    raddr = idx_r[AW-1:0];
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = ediv;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          dreq.start = 1'b1;
          dreq.dividend = in_cmd ? (in_free_address - base_r)
                                 : ({8'd0, in_request_bytes} + {19'd0, ediv} - 32'd1);
        end
      end
      S_STAMP: begin
        we = 1'b1;
        waddr = idx_r[AW-1:0];
        wdata = id_r;
      end
      S_FRWALK: begin
        if (rd_r == fid_r && idx_r < ecnt) begin
          we = 1'b1;
          waddr = idx_r[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  logic [31:0] need_c;
  logic [43:0] used_c;
  logic [43:0] freed_bytes_c;
  logic [44:0] free_sum_c;
  assign need_c = (drsp.quotient == '0) ? 32'd1 : drsp.quotient;
  // full run length comes from the rounding quotient
  assign used_c = 44'(div_q_r[CW-1:0]) * 44'(ediv);
  assign freed_bytes_c = 44'(freed_r) * 44'(ediv);
  assign free_sum_c = {22'd0, free_r} + {1'b0, freed_bytes_c};

  always_ff @(posedge clk) begin
    span_r <= 44'(ecnt) * 44'(ediv);
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      init_pend_r <= 1'b1;
      id_r        <= 8'd1;
      ovalid_r    <= 1'b0;
      base_r      <= '0;
      divb_r      <= 13'd64;
      cntcfg_r    <= 11'd1024;
      free_r      <= '0;
    end else begin
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      // cfg write to BASE, DIV or CNT restarts the clearing sweep
      if (cfg_we && (cfg_index == REG_BASE || cfg_index == REG_DIV ||
                     cfg_index == REG_CNT)) begin
        unique case (cfg_index)
          REG_BASE: base_r   <= cfg_wdata;
          REG_DIV:  divb_r   <= cfg_wdata[12:0];
          REG_CNT:  cntcfg_r <= cfg_wdata[10:0];
          default: ;
        endcase
        state_r     <= S_CLEAR;
        clr_r       <= '0;
        init_pend_r <= 1'b1;
      end else begin
        unique case (state_r)
          S_CLEAR: begin
            clr_r <= clr_r + 1'b1;
            if (clr_r == (AW+1)'(MAX_DIVISIONS - 1)) state_r <= S_IDLE;
          end
          S_IDLE: begin
            // span_r has settled long before the sweep ends
            if (init_pend_r) begin
              free_r      <= init_free;
              init_pend_r <= 1'b0;
            end
            if (accept) begin
              cmd_r   <= in_cmd;
              size_r  <= in_request_bytes;
              mask_r  <= (32'd1 << in_align_log2) - 32'd1;
              faddr_r <= in_free_address;
              state_r <= S_DIVWAIT;
            end
          end
          S_DIVWAIT: begin
            if (drsp.done) begin
              div_q_r <= drsp.quotient;
              need_r  <= need_c;
              run_len_r <= '0;
              cand_r  <= base_r;
              if (!cmd_r) begin
                if (size_r == '0) begin
                  ost_r <= ST_ZERO; ogr_r <= '0; state_r <= S_DONE;
                end else if ({9'd0, size_r} > {10'd0, free_r}) begin
                  ost_r <= ST_NOSPACE; ogr_r <= '0; state_r <= S_DONE;
                end else begin
                  idx_r   <= '0;
                  state_r <= S_SCANWAIT;
                end
              end else begin
                ogr_r <= '0;
                if (faddr_r < base_r || {12'd0, faddr_r - base_r} >= span_r
                    || drsp.quotient >= 32'(ecnt)) begin
                  ost_r <= ST_OUTSIDE; state_r <= S_DONE;
                end else begin
                  idx_r   <= drsp.quotient[CW-1:0];
                  state_r <= S_FRDWAIT;
                end
              end
            end
          end
          S_SCANWAIT: begin
            // read of entry idx_r in flight
            if (idx_r >= ecnt) begin
              ost_r <= ST_NOSPACE; ogr_r <= '0; state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
          S_SCAN: begin
            // rd_r holds entry idx_r
            if (rd_r != 8'd0) begin
              run_len_r <= '0;
              idx_r <= idx_r + 1'b1;
              cand_r <= cand_r + {19'd0, ediv};
              state_r <= S_SCANWAIT;
            end else if (run_len_r == '0 && (cand_r & mask_r) != '0) begin
              idx_r <= idx_r + 1'b1;
              cand_r <= cand_r + {19'd0, ediv};
              state_r <= S_SCANWAIT;
            end else begin
              if (run_len_r == '0) begin
                first_free_r <= idx_r[AW-1:0];
                run_addr_r   <= cand_r;
              end
              if (32'(run_len_r) + 32'd1 >= need_r) begin
                // found; rewind to run start and stamp
                idx_r <= (run_len_r == '0) ? idx_r : CW'(first_free_r);
                state_r <= S_STAMP;
              end else begin
                run_len_r <= run_len_r + 1'b1;
                idx_r <= idx_r + 1'b1;
                cand_r <= cand_r + {19'd0, ediv};
                state_r <= S_SCANWAIT;
              end
            end
          end
          S_STAMP: begin
            idx_r <= idx_r + 1'b1;
            need_r <= need_r - 32'd1;
            if (need_r == 32'd1) begin
              ogr_r <= run_addr_r;
              ost_r <= ST_OK;
              id_r  <= (id_r == 8'd255) ? 8'd1 : id_r + 8'd1;
              state_r <= S_DONE;
            end
          end
          S_FRDWAIT: state_r <= S_FRCHK;
          S_FRCHK: begin
            if (rd_r == 8'd0) begin
              ost_r <= ST_DOUBLE; state_r <= S_DONE;
            end else begin
              fid_r   <= rd_r;
              freed_r <= '0;
              state_r <= S_FRWALK;
            end
          end
          S_FRWALK: begin
            // rd_r is entry idx_r
            if (rd_r == fid_r && idx_r < ecnt) begin
              freed_r <= freed_r + 1'b1;
              idx_r   <= idx_r + 1'b1;
              state_r <= S_FRNEXT;
            end else begin
              free_r  <= (free_sum_c > {22'd0, FreeMax}) ? FreeMax : free_sum_c[22:0];
              ost_r   <= ST_OK;
              state_r <= S_DONE;
            end
          end
          // read of the next entry in flight
          S_FRNEXT: state_r <= S_FRWALK;
          S_DONE: begin
            ovalid_r <= 1'b1;
            state_r  <= S_IDLE;
          end
          default: state_r <= S_IDLE;
        endcase
        // subtract used bytes when the stamp finishes
        if (state_r == S_STAMP && need_r == 32'd1) begin
          free_r <= (used_c > 44'(free_r)) ? '0 : free_r - used_c[22:0];
        end
      end
    end
  end

  assign out_valid           = ovalid_r;
  assign out_granted_address = ogr_r;
  assign out_status          = ost_r;
  assign out_bytes_left      = free_r;

  property p_no_ready_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> !in_ready;
  endproperty
  a_no_ready_busy: assert property (p_no_ready_busy) else $error("ready while busy");

  property p_id_nonzero;
    @(posedge clk) disable iff (!rst_n) id_r != 8'd0;
  endproperty
  a_id_nonzero: assert property (p_id_nonzero) else $error("zero owner id");

  property p_free_bound;
    @(posedge clk) disable iff (!rst_n) out_valid |-> (out_status <= 3'(ST_ZERO));
  endproperty
  a_free_bound: assert property (p_free_bound) else $error("bad status");
endmodule

/* src/bra_divider.sv */
// bra_divider: shared restoring divider, one quotient bit per cycle
// depends on bra_pkg
module bra_divider
  import bra_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [31:0] quo_r, quo_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [12:0] dsr_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [13:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[12:0], quo_r[31]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[30:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt    = trial - {1'b0, dsr_r};
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) dsr_r <= req.divisor;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r[12:0];

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

  property p_busy_count;
    @(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != 6'd0;
  endproperty
  a_busy_count: assert property (p_busy_count) else $error("busy with zero count");

  property p_start_busy;
    @(posedge clk) disable iff (!rst_n) req.start |=> busy_r;
  endproperty
  a_start_busy: assert property (p_start_busy) else $error("start did not raise busy");
endmodule
